// ===== rtl/tsh_pkg.sv =====
package tsh_pkg;

    localparam int STATE_SIZE = 729;
    localparam int BLOCK_SIZE = 243;
    localparam int ROUND_STEP = 364;

    localparam int ADDR_W      = $clog2(STATE_SIZE);
    localparam int POS_W       = 8;
    localparam int ROUNDS_W    = 8;
    localparam int TRIT_W      = 2;
    localparam int CFG_INDEX_W = 2;

    // permutation counter: reads at 0..STATE_SIZE, writes go to the count minus two
    localparam int PERM_LAST = STATE_SIZE + 1;
    localparam int CNT_W     = $clog2(PERM_LAST + 1);

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = ROUNDS_W'(81);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ABSORB_ROUNDS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_ROUNDS = CFG_INDEX_W'(1);

    // stored trit codes; the table can also yield +2
    localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'b00;
    localparam logic [TRIT_W-1:0] TRIT_POS  = 2'b01;
    localparam logic [TRIT_W-1:0] TRIT_TWO  = 2'b10;
    localparam logic [TRIT_W-1:0] TRIT_NEG  = 2'b11;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SQ_WAIT,
        ST_PERM
    } tsh_state_t;

    // incoming balanced trit; the unused pattern saturates to -1
    function automatic logic [TRIT_W-1:0] trit_in(input logic [TRIT_W-1:0] v);
        trit_in = (v == TRIT_TWO) ? TRIT_NEG : v;
    endfunction

    // index = p + 4*t + 5 = (p+1) + 4*(t+1); code+1 maps -1,0,1,2 to 0..3
    function automatic logic [TRIT_W-1:0] sbox(input logic [TRIT_W-1:0] p,
                                               input logic [TRIT_W-1:0] t);
        logic [TRIT_W-1:0] p1;
        logic [TRIT_W-1:0] t1;
        logic [3:0]        idx;
        p1  = p + 2'd1;
        t1  = t + 2'd1;
        idx = {t1, p1};
        case (idx)
            4'd0:    sbox = TRIT_POS;
            4'd1:    sbox = TRIT_ZERO;
            4'd2:    sbox = TRIT_NEG;
            4'd3:    sbox = TRIT_TWO;
            4'd4:    sbox = TRIT_POS;
            4'd5:    sbox = TRIT_NEG;
            4'd6:    sbox = TRIT_ZERO;
            4'd7:    sbox = TRIT_TWO;
            4'd8:    sbox = TRIT_NEG;
            4'd9:    sbox = TRIT_POS;
            4'd10:   sbox = TRIT_ZERO;
            default: sbox = TRIT_NEG;   // out of table: biased entry
        endcase
    endfunction

endpackage

// ===== rtl/tsh_ram.sv =====
module tsh_ram #(
    parameter int DEPTH = 729,
    parameter int WIDTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ternary_sponge_hash.sv =====
// Trit-serial Curl-style sponge hash over a 729-trit state.
//
// Item channel (item_valid / item_stall): one transfer is one absorb or one
// squeeze trit. Absorb writes trit_value into the next of the 243 block
// positions; first_of_message clears the whole state beforehand. Squeeze
// returns the state trit at the block position on the result channel
// (result_valid / result_stall). A full block or last_trit starts the
// permutation with the absorb or squeeze round count; a zero count only rewinds.
// Sequence: an absorb passes through the write state; a squeeze reads the
// state trit, then loads the result register (later while a previous result
// is still stalled). A first flag adds a clearing sweep before the write.
// Each permutation round does one state memory read per cycle, the new trit
// written into the other bank (ping-pong between two 729x2 memories).
// Reset: a sweep zeroes the state; item_stall is high meanwhile.
// Config writes (cfg_valid / cfg_ready, always ready) are taken at any time
// but must only be issued while the block is idle.
// A stalled result holds in the output register; the core meanwhile goes on
// with the permutation and takes the next item, but the following squeeze
// waits until the held result has been transferred.
module ternary_sponge_hash
    import tsh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic                    action,
    input  logic signed [1:0]       trit_value,
    input  logic                    first_of_message,
    input  logic                    last_trit,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [1:0]       trit_out,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ROUNDS_W-1:0]     cfg_data
);

    tsh_state_t state_reg, state_next;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [TRIT_W-1:0]   prev_reg, prev_next;
    logic                bank_reg, bank_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [ROUNDS_W-1:0] rounds_left_reg, rounds_left_next;
    logic                act_reg, act_next;
    logic [TRIT_W-1:0]   trit_reg, trit_next;
    logic                first_reg, first_next;
    logic                last_reg, last_next;
    logic [ROUNDS_W-1:0] absorb_count_reg, absorb_count_next;
    logic [ROUNDS_W-1:0] squeeze_count_reg, squeeze_count_next;
    logic                result_valid_reg, result_valid_next;
    logic [TRIT_W-1:0]   trit_out_reg, trit_out_next;

    logic                item_accept;
    logic                sq_load;
    logic                done_item;
    logic                perm_end;
    logic                clear_end;
    logic                trig;
    logic [POS_W-1:0]    pos_inc;
    logic [ROUNDS_W-1:0] sel_rounds;
    logic [ADDR_W:0]     step_sum;
    logic [ADDR_W-1:0]   step_addr;

    // memory ports
    logic                cur_wr_en;
    logic [ADDR_W-1:0]   cur_wr_addr;
    logic [TRIT_W-1:0]   cur_wr_data;
    logic                perm_wr_en;
    logic [ADDR_W-1:0]   perm_wr_addr;
    logic [TRIT_W-1:0]   perm_wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                ram0_wr_en, ram1_wr_en;
    logic [ADDR_W-1:0]   ram0_wr_addr, ram1_wr_addr;
    logic [TRIT_W-1:0]   ram0_wr_data, ram1_wr_data;
    logic [TRIT_W-1:0]   rd0_data, rd1_data, rd_sel;

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign trit_out     = trit_out_reg;

    assign sq_load   = (state_reg == ST_SQ_WAIT) && (!result_valid_reg || !result_stall);
    assign done_item = (state_reg == ST_WRITE) || sq_load;
    assign perm_end  = (state_reg == ST_PERM) && (cnt_reg == CNT_W'(PERM_LAST));
    assign clear_end = (state_reg == ST_CLEAR) && (cnt_reg == CNT_W'(STATE_SIZE - 1));

    assign pos_inc    = pos_reg + POS_W'(1);
    assign trig       = (pos_inc == POS_W'(BLOCK_SIZE)) || last_reg;
    assign sel_rounds = act_reg ? squeeze_count_reg : absorb_count_reg;

    // read address walks 0, 364, 728, ... modulo the state size
    assign step_sum  = {1'b0, addr_reg} + (ADDR_W + 1)'(ROUND_STEP);
    assign step_addr = (step_sum >= (ADDR_W + 1)'(STATE_SIZE))
                     ? ADDR_W'(step_sum - (ADDR_W + 1)'(STATE_SIZE))
                     : ADDR_W'(step_sum);

    assign rd_sel = bank_reg ? rd1_data : rd0_data;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_end)
                begin
                    state_next = first_reg ? ST_WRITE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (action)
                    begin
                        state_next = ST_SQ_WAIT;
                    end
                    else
                    begin
                        state_next = first_of_message ? ST_CLEAR : ST_WRITE;
                    end
                end
            end
            ST_WRITE, ST_SQ_WAIT:
            begin
                if (done_item)
                begin
                    state_next = (trig && (sel_rounds != '0)) ? ST_PERM : ST_IDLE;
                end
            end
            ST_PERM:
            begin
                if (perm_end && (rounds_left_reg == ROUNDS_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next            = cnt_reg;
        addr_next           = addr_reg;
        prev_next           = prev_reg;
        bank_next           = bank_reg;
        pos_next            = pos_reg;
        rounds_left_next    = rounds_left_reg;
        act_next            = act_reg;
        trit_next           = trit_reg;
        first_next          = first_reg;
        last_next           = last_reg;
        absorb_count_next   = absorb_count_reg;
        squeeze_count_next  = squeeze_count_reg;
        result_valid_next   = result_valid_reg && result_stall;
        trit_out_next       = trit_out_reg;

        cur_wr_en    = 1'b0;
        cur_wr_addr  = cnt_reg[ADDR_W-1:0];
        cur_wr_data  = TRIT_ZERO;
        perm_wr_en   = 1'b0;
        perm_wr_addr = ADDR_W'(cnt_reg - CNT_W'(2));
        perm_wr_data = sbox(prev_reg, rd_sel);
        rd_en        = 1'b0;
        rd_addr      = addr_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ABSORB_ROUNDS:  absorb_count_next  = cfg_data;
                REG_SQUEEZE_ROUNDS: squeeze_count_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                cur_wr_en = 1'b1;
                cnt_next  = clear_end ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    act_next   = action;
                    trit_next  = trit_in(trit_value);
                    first_next = first_of_message && !action;
                    last_next  = last_trit;
                    cnt_next   = '0;
                    if (action)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_W'(pos_reg);
                    end
                    else if (first_of_message)
                    begin
                        pos_next = '0;
                    end
                end
            end
            ST_WRITE:
            begin
                cur_wr_en   = 1'b1;
                cur_wr_addr = ADDR_W'(pos_reg);
                cur_wr_data = trit_reg;
            end
            ST_SQ_WAIT:
            begin
                if (sq_load)
                begin
                    result_valid_next = 1'b1;
                    trit_out_next     = rd_sel;
                end
            end
            ST_PERM:
            begin
                prev_next = rd_sel;
                if (cnt_reg <= CNT_W'(STATE_SIZE))
                begin
                    rd_en     = 1'b1;
                    addr_next = step_addr;
                end
                if (cnt_reg >= CNT_W'(2))
                begin
                    perm_wr_en = 1'b1;
                end
                if (perm_end)
                begin
                    cnt_next         = '0;
                    addr_next        = '0;
                    bank_next        = !bank_reg;
                    rounds_left_next = rounds_left_reg - ROUNDS_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase

        if (done_item)
        begin
            pos_next         = trig ? '0 : pos_inc;
            rounds_left_next = sel_rounds;
            cnt_next         = '0;
            addr_next        = '0;
        end
    end

    // current bank takes clears and absorbs, the other one round output
    assign ram0_wr_en   = bank_reg ? perm_wr_en   : cur_wr_en;
    assign ram0_wr_addr = bank_reg ? perm_wr_addr : cur_wr_addr;
    assign ram0_wr_data = bank_reg ? perm_wr_data : cur_wr_data;
    assign ram1_wr_en   = bank_reg ? cur_wr_en    : perm_wr_en;
    assign ram1_wr_addr = bank_reg ? cur_wr_addr  : perm_wr_addr;
    assign ram1_wr_data = bank_reg ? cur_wr_data  : perm_wr_data;

    tsh_ram #(
        .DEPTH (STATE_SIZE),
        .WIDTH (TRIT_W)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (ram0_wr_en),
        .wr_addr (ram0_wr_addr),
        .wr_data (ram0_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd0_data)
    );

    tsh_ram #(
        .DEPTH (STATE_SIZE),
        .WIDTH (TRIT_W)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (ram1_wr_en),
        .wr_addr (ram1_wr_addr),
        .wr_data (ram1_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd1_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            cnt_reg            <= '0;
            addr_reg           <= '0;
            bank_reg           <= 1'b0;
            pos_reg            <= '0;
            rounds_left_reg    <= '0;
            act_reg            <= 1'b0;
            first_reg          <= 1'b0;
            last_reg           <= 1'b0;
            absorb_count_reg   <= ROUNDS_RESET;
            squeeze_count_reg  <= ROUNDS_RESET;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            cnt_reg            <= cnt_next;
            addr_reg           <= addr_next;
            bank_reg           <= bank_next;
            pos_reg            <= pos_next;
            rounds_left_reg    <= rounds_left_next;
            act_reg            <= act_next;
            first_reg          <= first_next;
            last_reg           <= last_next;
            absorb_count_reg   <= absorb_count_next;
            squeeze_count_reg  <= squeeze_count_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        trit_reg     <= trit_next;
        trit_out_reg <= trit_out_next;
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(BLOCK_SIZE))
        else $error("block position out of range");

    a_perm_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PERM) |-> (rounds_left_reg != '0))
        else $error("permutation running with no rounds left");

    a_perm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PERM) |-> (cnt_reg <= CNT_W'(PERM_LAST)))
        else $error("round counter overran");

    a_squeeze_read: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && action) |=> (state_reg == ST_SQ_WAIT))
        else $error("squeeze transfer did not wait for read data");

    a_clear_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (clear_end && first_reg) |=> ((state_reg == ST_WRITE) && (pos_reg == '0)))
        else $error("first trit not written at block start after clear");
`endif

endmodule

// ===== sim/tsh_checker.sv =====
package tsh_tb_pkg;

    // item operation carried on the action port
    typedef enum logic {
        ACT_ABSORB  = 1'b0,
        ACT_SQUEEZE = 1'b1
    } action_t;

endpackage

// Watches the item, result and register channels, keeps its own copy of the
// sponge and compares every squeezed trit with the predicted one.
module tsh_checker
    import tsh_pkg::*;
    import tsh_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  logic                   action,
    input  logic [TRIT_W-1:0]      trit_value,
    input  logic                   first_of_message,
    input  logic                   last_trit,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  logic [TRIT_W-1:0]      trit_out,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ROUNDS_W-1:0]    cfg_data,
    output int                     errors,
    output int                     pending,
    output int                     trits_checked,
    output int                     permutations
);

    localparam int MAX_REPORTS = 10;
    localparam int MIX_BIAS    = 5;

    logic [TRIT_W-1:0]   sponge_trits [STATE_SIZE];
    logic [TRIT_W-1:0]   round_snap [STATE_SIZE];
    logic [TRIT_W-1:0]   hash_trits_due [$];
    logic [POS_W-1:0]    rate_pos;
    logic [ROUNDS_W-1:0] absorb_count;
    logic [ROUNDS_W-1:0] squeeze_count;
    logic [TRIT_W-1:0]   want;
    int                  n_err;
    int                  n_checked;
    int                  n_perm;
    int                  i;

    function automatic int trit_num(input logic [TRIT_W-1:0] c);
        case (c)
            TRIT_POS: trit_num = 1;
            TRIT_TWO: trit_num = 2;
            TRIT_NEG: trit_num = -1;
            default:  trit_num = 0;
        endcase
    endfunction

    // mixing table, p + 4t + 5; anything off the table uses the bias entry (-1)
    function automatic int mix_value(input int idx);
        case (idx) inside
            0, 4, 9:  mix_value = 1;
            1, 6, 10: mix_value = 0;
            3, 7:     mix_value = 2;
            default:  mix_value = -1;
        endcase
    endfunction

    task automatic scramble(input logic [ROUNDS_W-1:0] rounds);
        int r;
        int s;
        int p;
        int t;
        for (r = 0; r < rounds; r++)
        begin
            for (s = 0; s < STATE_SIZE; s++)
                round_snap[s] = sponge_trits[s];
            t = 0;
            for (s = 0; s < STATE_SIZE; s++)
            begin
                p = t;
                t = (t + ROUND_STEP) % STATE_SIZE;
                sponge_trits[s] = TRIT_W'(mix_value(trit_num(round_snap[p])
                                  + 4 * trit_num(round_snap[t]) + MIX_BIAS));
            end
        end
        n_perm++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < STATE_SIZE; i++)
                sponge_trits[i] = TRIT_ZERO;
            hash_trits_due.delete();
            rate_pos       = '0;
            absorb_count   = ROUNDS_RESET;
            squeeze_count  = ROUNDS_RESET;
            n_err          = 0;
            n_checked      = 0;
            n_perm         = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ABSORB_ROUNDS)
                    absorb_count = cfg_data;
                else if (cfg_index == REG_SQUEEZE_ROUNDS)
                    squeeze_count = cfg_data;
            end

            if (result_valid && !result_stall)
            begin
                n_checked++;
                if (hash_trits_due.size() == 0)
                begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("[%0t] unexpected result trit_out=%b", $realtime, trit_out);
                end
                else
                begin
                    want = hash_trits_due.pop_front();
                    if (trit_out !== want)
                    begin
                        n_err++;
                        if (n_err <= MAX_REPORTS)
                            $display("[%0t] result %0d: trit_out expected %b got %b",
                                     $realtime, n_checked, want, trit_out);
                    end
                end
            end

            if (item_valid && !item_stall)
            begin
                if (rate_pos >= BLOCK_SIZE)
                    rate_pos = '0;
                if (action == ACT_SQUEEZE)
                    hash_trits_due.push_back(sponge_trits[ADDR_W'(rate_pos)]);
                else
                begin
                    if (first_of_message)
                    begin
                        for (i = 0; i < STATE_SIZE; i++)
                            sponge_trits[i] = TRIT_ZERO;
                        rate_pos = '0;
                    end
                    // only +1 and 0 pass; both other patterns read as -1
                    sponge_trits[ADDR_W'(rate_pos)] = (trit_value == TRIT_POS ||
                                                       trit_value == TRIT_ZERO)
                                                      ? trit_value : TRIT_NEG;
                end
                rate_pos = rate_pos + 1'b1;
                if (rate_pos >= BLOCK_SIZE || last_trit)
                begin
                    scramble(action == ACT_SQUEEZE ? squeeze_count : absorb_count);
                    rate_pos = '0;
                end
            end
        end
        errors        <= n_err;
        pending       <= hash_trits_due.size();
        trits_checked <= n_checked;
        permutations  <= n_perm;
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the trit-serial sponge hash.
// Makes the item and register traffic, drives the result-side stall and
// hands the verdict; all prediction and comparison live in tsh_checker.
module tb_top;
    import tsh_pkg::*;
    import tsh_tb_pkg::*;

    // a 255-round permutation passes with no transfer at all;
    // the limit covers it about three times over
    localparam int WATCHDOG_LIMIT = 600000;
    localparam int RESET_CYCLES   = 12;
    localparam int ROUND_CYCLES   = STATE_SIZE + 2;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_stall;
    logic                    action = ACT_ABSORB;
    logic signed [1:0]       trit_value = TRIT_ZERO;
    logic                    first_of_message = 1'b0;
    logic                    last_trit = 1'b0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic signed [1:0]       trit_out;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = REG_ABSORB_ROUNDS;
    logic [ROUNDS_W-1:0]     cfg_data = '0;

    int  chk_errors;
    int  chk_pending;
    int  chk_trits;
    int  chk_perms;

    // stimulus-side bookkeeping
    bit  tx_idle = 1'b0;         // sender gaps on/off
    bit  rx_idle = 1'b0;         // result stall bursts on/off
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  items_sent = 0;
    int  settings_used = 1;      // reset values count as the first setting
    int  fill_pos = 0;           // mirror of the block position, for drain timing only
    int  absorb_count_now = 81;
    int  squeeze_count_now = 81;
    int  drain_cycles = 0;       // pause needed after the last transfer went in

    always #4 clk = ~clk;

    ternary_sponge_hash uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .action           (action),
        .trit_value       (trit_value),
        .first_of_message (first_of_message),
        .last_trit        (last_trit),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .trit_out         (trit_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    tsh_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .action           (action),
        .trit_value       (trit_value),
        .first_of_message (first_of_message),
        .last_trit        (last_trit),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .trit_out         (trit_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .errors           (chk_errors),
        .pending          (chk_pending),
        .trits_checked    (chk_trits),
        .permutations     (chk_perms)
    );

    // Result side: random stall bursts while rx_idle is set.
    always @(posedge clk)
    begin
        if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            stall_left   <= 0;
            result_stall <= 1'b0;
        end
        else if (rx_idle && $urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(1, 8);
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, chk_pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // One item transfer. An optional gap (valid low) comes first; otherwise
    // valid stays high straight from the previous transfer.
    task automatic send_item(input action_t act, input logic [1:0] code,
                             input logic is_first, input logic is_last);
        int rounds;
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item_valid       <= 1'b1;
        action           <= act;
        trit_value       <= code;
        first_of_message <= is_first;
        last_trit        <= is_last;
        do @(posedge clk); while (item_stall);
        items_sent++;

        // Track whether this transfer kicked off a permutation, so the drain
        // before a register write knows how long the core may stay busy.
        if (act == ACT_ABSORB && is_first)
            fill_pos = 0;
        fill_pos++;
        if (fill_pos >= BLOCK_SIZE || is_last)
        begin
            fill_pos     = 0;
            rounds       = (act == ACT_SQUEEZE) ? squeeze_count_now : absorb_count_now;
            drain_cycles = (rounds + 1) * ROUND_CYCLES + 16;
        end
        else
            drain_cycles = STATE_SIZE + 16;   // covers a clearing sweep
    endtask

    // Sender holds off until every predicted trit has been taken.
    task automatic wait_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    // Full quiet point: results drained and any trailing permutation done.
    task automatic settle();
        wait_results();
        repeat (drain_cycles) @(posedge clk);
    endtask

    // Writes both round counts back to back; valid drops only after the second.
    task automatic set_rounds(input int absorb_n, input int squeeze_n);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_ABSORB_ROUNDS;
        cfg_data  <= ROUNDS_W'(absorb_n);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_SQUEEZE_ROUNDS;
        cfg_data  <= ROUNDS_W'(squeeze_n);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        absorb_count_now  = absorb_n;
        squeeze_count_now = squeeze_n;
        settings_used++;
    endtask

    function automatic logic [1:0] any_trit();
        any_trit = 2'($urandom_range(0, 3));   // includes the saturating 10b pattern
    endfunction

    // Random traffic. Mostly well-formed: a message opened by a first flag and
    // closed by last, then a squeezed digest closed by last. Lengths are
    // mostly short, sometimes long enough to fill a 243-trit block on either
    // side. The rest is unstructured noise and an occasional full drain.
    // Groups are cut short at the end so the phase sends n_items exactly.
    task automatic random_traffic(input int n_items, input bit allow_idle);
        int start;
        int len;
        int k;
        int pick;
        int left;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            tx_idle = allow_idle && ($urandom_range(0, 3) != 0);
            rx_idle = allow_idle && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 300)
                                                  : $urandom_range(1, 40);
                left = n_items - (items_sent - start);
                if (len > left)
                    len = left;
                for (k = 0; k < len; k++)
                    send_item(ACT_ABSORB, any_trit(), k == 0, k == len - 1);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(243, 250)
                                                  : $urandom_range(1, 30);
                left = n_items - (items_sent - start);
                if (len > left)
                    len = left;
                for (k = 0; k < len; k++)
                    send_item(ACT_SQUEEZE, any_trit(), $urandom_range(0, 7) == 0,
                              k == len - 1);
            end
            else if (pick < 95)
            begin
                len = $urandom_range(1, 10);
                left = n_items - (items_sent - start);
                if (len > left)
                    len = left;
                for (k = 0; k < len; k++)
                    send_item($urandom_range(0, 1) ? ACT_SQUEEZE : ACT_ABSORB, any_trit(),
                              $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
            end
            else
                wait_results();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // ---- directed, reset round counts (81 / 81) ----
        send_item(ACT_ABSORB, TRIT_POS, 1'b1, 1'b0);
        send_item(ACT_ABSORB, TRIT_ZERO, 1'b0, 1'b0);
        send_item(ACT_ABSORB, TRIT_NEG, 1'b0, 1'b0);
        send_item(ACT_ABSORB, TRIT_TWO, 1'b0, 1'b0);     // unused pattern -> -1
        send_item(ACT_SQUEEZE, TRIT_POS, 1'b1, 1'b0);    // first flag is a no-op here
        send_item(ACT_ABSORB, TRIT_POS, 1'b0, 1'b1);     // absorb permutation
        send_item(ACT_SQUEEZE, TRIT_NEG, 1'b0, 1'b0);
        send_item(ACT_SQUEEZE, TRIT_TWO, 1'b0, 1'b0);
        send_item(ACT_SQUEEZE, TRIT_POS, 1'b0, 1'b1);    // squeeze permutation
        send_item(ACT_SQUEEZE, TRIT_ZERO, 1'b0, 1'b0);
        send_item(ACT_SQUEEZE, TRIT_ZERO, 1'b0, 1'b0);

        // ---- longest absorb permutation, squeeze count zero ----
        // A zero count must only rewind the block position; the trailing
        // squeeze rereads position 0 and also marks the end of the busy time.
        set_rounds(255, 0);
        send_item(ACT_ABSORB, TRIT_NEG, 1'b1, 1'b0);
        send_item(ACT_ABSORB, TRIT_POS, 1'b0, 1'b1);
        send_item(ACT_SQUEEZE, TRIT_ZERO, 1'b0, 1'b0);
        send_item(ACT_SQUEEZE, TRIT_ZERO, 1'b0, 1'b1);
        send_item(ACT_SQUEEZE, TRIT_ZERO, 1'b0, 1'b0);

        // ---- absorb count zero, longest squeeze permutation ----
        set_rounds(0, 255);
        send_item(ACT_ABSORB, TRIT_POS, 1'b1, 1'b1);
        send_item(ACT_SQUEEZE, TRIT_ZERO, 1'b0, 1'b0);
        send_item(ACT_SQUEEZE, TRIT_NEG, 1'b0, 1'b1);
        send_item(ACT_SQUEEZE, TRIT_ZERO, 1'b0, 1'b0);

        // ---- random phases with short permutations ----
        set_rounds(1, 2);
        random_traffic(400, 1'b1);
        wait_results();                                  // sender pause, results all in
        set_rounds(3, 1);
        random_traffic(400, 1'b1);
        set_rounds(2, 5);
        random_traffic(350, 1'b1);

        // last stretch at full rate on both sides
        set_rounds(1, 1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        random_traffic(400, 1'b0);
        settle();

        $display("Sent %0d items over %0d round-count settings (0 and 255 included);",
                 items_sent, settings_used);
        $display("checked %0d squeezed trits across %0d permutations.",
                 chk_trits, chk_perms);
        if (chk_errors == 0 && chk_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tsh_pkg.sv
rtl/tsh_ram.sv
rtl/ternary_sponge_hash.sv
sim/tsh_checker.sv
sim/tb_top.sv
